FILE: hdl/fpt_pkg.sv
`default_nettype none

package fpt_pkg;

   // Table geometry.
   localparam int MAX_FAULTS = 32;
   localparam int IDX_W      = $clog2(MAX_FAULTS);
   localparam int CNT_W      = $clog2(MAX_FAULTS + 1);

   // Item kinds.
   localparam logic KIND_RAISE = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   // Result status codes.
   localparam logic [2:0] STATUS_INSERTED  = 3'd0;
   localparam logic [2:0] STATUS_PRESENT   = 3'd1;
   localparam logic [2:0] STATUS_REMOVED   = 3'd2;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd3;
   localparam logic [2:0] STATUS_FULL      = 3'd4;

   // Pause classes.
   localparam logic [1:0] CLASS_NONE      = 2'd0;
   localparam logic [1:0] CLASS_PAUSE     = 2'd1;
   localparam logic [1:0] CLASS_PAUSE_MAN = 2'd2;
   localparam logic [1:0] CLASS_EMERGENCY = 2'd3;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ERROR_LEVEL   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WARNING_LEVEL = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NONE_RESPONSE = 2'd2;

   localparam logic [2:0] ERROR_LEVEL_RESET   = 3'd3;
   localparam logic [2:0] WARNING_LEVEL_RESET = 3'd2;
   localparam logic [3:0] NONE_RESPONSE_RESET = 4'd0;

   typedef struct packed {
      logic        kind;
      logic [15:0] fault_id;
      logic [7:0]  fault_priority;
      logic [3:0]  response_code;
      logic [2:0]  fault_level;
      logic [1:0]  pause_class;
      logic        handle;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        top_valid;
      logic [15:0] top_code;
      logic [5:0]  fault_count;
      logic        evaluated;
      logic        move_pause;
      logic        pause_latched;
      logic        emergency;
   } rsp_type;

   // One stored fault.
   typedef struct packed {
      logic [15:0] code;
      logic [7:0]  prio;
      logic [3:0]  resp;
      logic [2:0]  level;
      logic [1:0]  pclass;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [2:0] error_level;
      logic [2:0] warning_level;
      logic [3:0] none_response_code;
   } cfg_type;

   // Outcome of comparing the item against one stored entry.
   typedef struct packed {
      logic code_eq;
      logic outranks;
      logic move_pause;
      logic pause_latched;
      logic emergency;
   } cmp_type;

   // Table memory access from the sequencer.
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
      logic [IDX_W-1:0] rd_addr;
   } mem_req_type;

endpackage

`default_nettype wire

FILE: hdl/fault_priority_table.sv
// Fault priority table.
// Raise and clear requests arrive on the req_ channel (req_valid, req_stall,
// req_data); each one produces exactly one result transfer on the rsp_
// channel (rsp_valid, rsp_stall, rsp_data) with the status, the top fault
// code, the fault count and the outcome of the response evaluation.
// The block works on one request at a time. A search pass over the held
// faults is followed by the decision; an insert then shifts and places, a
// removal shifts, and the response evaluation pass follows if the request is
// handled, reaches the error level and names a response other than the none
// code. The result is then loaded into the output register once that is
// free (with no shift or evaluation pass when the table is left unchanged),
// and the next request is taken only after that. All passes go through the
// single read port of the table memory. req_stall is high from acceptance
// until the result is loaded.
// A finished result waits in the output register while rsp_stall is high;
// a new request may be accepted meanwhile, but its result is only loaded
// once the previous one has been transferred.
// Reset empties the table, drops any pending result and restores the
// configuration registers; csr_ writes may come at any time the block idles.
`default_nettype none

module fault_priority_table (
   input  wire logic                                 clock,
   input  wire logic                                 reset,

   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire fpt_pkg::req_type                     req_data,

   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output fpt_pkg::rsp_type                          rsp_data,

   input  wire logic                                 csr_we,
   input  wire logic [fpt_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [fpt_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   fpt_pkg::cfg_type     cfg_ff, cfg_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   fpt_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   logic                 start;
   logic                 idle;
   logic                 done;
   logic                 rsp_free;
   fpt_pkg::rsp_type     result;
   fpt_pkg::mem_req_type mem;
   logic [fpt_pkg::ENTRY_W-1:0] rd_bits;

   // A request transfer happens when the sequencer sits idle.
   assign req_stall = !idle;
   assign start     = req_valid && !req_stall;

   // The output register can take a new result when it is empty or is
   // being emptied in this cycle.
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   fpt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req      (req_data),
      .cfg      (cfg_ff),
      .rsp_free (rsp_free),
      .rd_data  (fpt_pkg::entry_type'(rd_bits)),
      .mem      (mem),
      .idle     (idle),
      .done     (done),
      .result   (result)
   );

   // Table storage; entries beyond the count are never used.
   fpt_ram #(
      .WIDTH (fpt_pkg::ENTRY_W),
      .DEPTH (fpt_pkg::MAX_FAULTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem.wr_en),
      .wr_addr (mem.wr_addr),
      .wr_data (mem.wr_data),
      .rd_addr (mem.rd_addr),
      .rd_data (rd_bits)
   );

   // Configuration writes; an index outside the register list is ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            fpt_pkg::CSR_ERROR_LEVEL: begin
               cfg_in.error_level = csr_wdata[2:0];
            end
            fpt_pkg::CSR_WARNING_LEVEL: begin
               cfg_in.warning_level = csr_wdata[2:0];
            end
            fpt_pkg::CSR_NONE_RESPONSE: begin
               cfg_in.none_response_code = csr_wdata[3:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // Output register: loaded when the sequencer finishes, cleared once the
   // receiver takes the transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.error_level        <= fpt_pkg::ERROR_LEVEL_RESET;
         cfg_ff.warning_level      <= fpt_pkg::WARNING_LEVEL_RESET;
         cfg_ff.none_response_code <= fpt_pkg::NONE_RESPONSE_RESET;
         rsp_valid_ff              <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: hdl/fpt_ram.sv
`default_nettype none

module fpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: hdl/fpt_cmp.sv
`default_nettype none

// Compares the current item against one stored entry per cycle.
module fpt_cmp (
   input  wire fpt_pkg::entry_type trig,
   input  wire fpt_pkg::entry_type stored,
   input  wire logic [2:0]         warning_level,
   output fpt_pkg::cmp_type        result
);

   logic contributes;

   always_comb begin
      result.code_eq = (trig.code == stored.code);

      if (trig.prio != stored.prio) begin
         result.outranks = (trig.prio > stored.prio);
      end else if (trig.resp != stored.resp) begin
         result.outranks = (trig.resp > stored.resp);
      end else begin
         result.outranks = (trig.level > stored.level);
      end

      contributes = (stored.level > warning_level);
      result.move_pause    = contributes &&
                             ((stored.pclass == fpt_pkg::CLASS_PAUSE) ||
                              (stored.pclass == fpt_pkg::CLASS_PAUSE_MAN));
      result.pause_latched = contributes && (stored.pclass == fpt_pkg::CLASS_PAUSE_MAN);
      result.emergency     = contributes && (stored.pclass == fpt_pkg::CLASS_EMERGENCY);
   end

endmodule

`default_nettype wire

FILE: hdl/fpt_ctrl.sv
`default_nettype none

// Sequencer: search pass, decision, shift pass, placement and evaluation
// pass over the table memory; search and evaluation share one compare unit.
module fpt_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire fpt_pkg::req_type    req,
   input  wire fpt_pkg::cfg_type    cfg,
   input  wire logic                rsp_free,
   input  wire fpt_pkg::entry_type  rd_data,
   output fpt_pkg::mem_req_type     mem,
   output logic                     idle,
   output logic                     done,
   output fpt_pkg::rsp_type         result
);

   localparam int CNT_W = fpt_pkg::CNT_W;
   localparam int IDX_W = fpt_pkg::IDX_W;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SEARCH = 7'b0000010,
      ST_DECIDE = 7'b0000100,
      ST_SHIFT  = 7'b0001000,
      ST_PLACE  = 7'b0010000,
      ST_EVAL   = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic               kind_ff, kind_in;
   logic               handle_ff, handle_in;
   fpt_pkg::entry_type trig_ff, trig_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   pidx_ff, pidx_in;
   logic               pend_ff, pend_in;
   logic               iss_ff, iss_in;
   logic               found_ff, found_in;
   logic [CNT_W-1:0]   fpos_ff, fpos_in;
   logic               ins_found_ff, ins_found_in;
   logic [CNT_W-1:0]   ipos_ff, ipos_in;
   logic [2:0]         status_ff, status_in;
   logic               eval_ff, eval_in;
   logic               pm_ff, pm_in;
   logic               pl_ff, pl_in;
   logic               em_ff, em_in;
   logic [15:0]        top_code_ff, top_code_in;

   fpt_pkg::cmp_type   cmp;
   logic               eval_go;
   logic [CNT_W-1:0]   pos;
   logic [CNT_W-1:0]   idx_next;
   logic [CNT_W-1:0]   wr_idx;

   fpt_cmp u_cmp (
      .trig          (trig_ff),
      .stored        (rd_data),
      .warning_level (cfg.warning_level),
      .result        (cmp)
   );

   assign eval_go = handle_ff && (trig_ff.level >= cfg.error_level) &&
                    (trig_ff.resp != cfg.none_response_code);
   assign idx_next = idx_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      handle_in    = handle_ff;
      trig_in      = trig_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pidx_in      = pidx_ff;
      pend_in      = pend_ff;
      iss_in       = iss_ff;
      found_in     = found_ff;
      fpos_in      = fpos_ff;
      ins_found_in = ins_found_ff;
      ipos_in      = ipos_ff;
      status_in    = status_ff;
      eval_in      = eval_ff;
      pm_in        = pm_ff;
      pl_in        = pl_ff;
      em_in        = em_ff;
      top_code_in  = top_code_ff;
      done         = 1'b0;
      pos          = ins_found_ff ? ipos_ff : count_ff;
      wr_idx       = '0;
      mem          = '0;
      mem.rd_addr  = idx_ff[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               kind_in        = req.kind;
               handle_in      = req.handle;
               trig_in.code   = req.fault_id;
               trig_in.prio   = req.fault_priority;
               trig_in.resp   = req.response_code;
               trig_in.level  = req.fault_level;
               trig_in.pclass = req.pause_class;
               idx_in         = '0;
               pend_in        = 1'b0;
               found_in       = 1'b0;
               ins_found_in   = 1'b0;
               eval_in        = 1'b0;
               pm_in          = 1'b0;
               pl_in          = 1'b0;
               em_in          = 1'b0;
               state_in       = ST_SEARCH;
            end
         end

         ST_SEARCH: begin
            pend_in = 1'b0;
            if (idx_ff < count_ff) begin
               pend_in = 1'b1;
               pidx_in = idx_ff;
               idx_in  = idx_next;
            end
            if (pend_ff) begin
               if (cmp.code_eq && !found_ff) begin
                  found_in = 1'b1;
                  fpos_in  = pidx_ff;
                  if (kind_ff == fpt_pkg::KIND_CLEAR) begin
                     trig_in = rd_data;
                  end
               end
               if ((kind_ff == fpt_pkg::KIND_RAISE) && cmp.outranks && !ins_found_ff) begin
                  ins_found_in = 1'b1;
                  ipos_in      = pidx_ff;
               end
            end
            if ((idx_ff >= count_ff) && !pend_ff) begin
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            pend_in = 1'b0;
            if (kind_ff == fpt_pkg::KIND_RAISE) begin
               if (found_ff) begin
                  status_in = fpt_pkg::STATUS_PRESENT;
                  state_in  = ST_DONE;
               end else if (count_ff == CNT_W'(fpt_pkg::MAX_FAULTS)) begin
                  status_in = fpt_pkg::STATUS_FULL;
                  state_in  = ST_DONE;
               end else begin
                  status_in = fpt_pkg::STATUS_INSERTED;
                  fpos_in   = pos;
                  if (pos == count_ff) begin
                     state_in = ST_PLACE;
                  end else begin
                     idx_in   = count_ff - 1'b1;
                     iss_in   = 1'b1;
                     state_in = ST_SHIFT;
                  end
               end
            end else begin
               if (!found_ff) begin
                  status_in = fpt_pkg::STATUS_NOT_FOUND;
                  state_in  = ST_DONE;
               end else begin
                  status_in = fpt_pkg::STATUS_REMOVED;
                  idx_in    = fpos_ff + 1'b1;
                  iss_in    = ((fpos_ff + 1'b1) < count_ff);
                  state_in  = ST_SHIFT;
               end
            end
         end

         ST_SHIFT: begin
            pend_in = 1'b0;
            if (iss_ff) begin
               pend_in = 1'b1;
               pidx_in = idx_ff;
               if (kind_ff == fpt_pkg::KIND_RAISE) begin
                  if (idx_ff == fpos_ff) begin
                     iss_in = 1'b0;
                  end else begin
                     idx_in = idx_ff - 1'b1;
                  end
               end else begin
                  idx_in = idx_next;
                  iss_in = (idx_next < count_ff);
               end
            end
            if (pend_ff) begin
               wr_idx      = (kind_ff == fpt_pkg::KIND_RAISE) ? pidx_ff + 1'b1
                                                              : pidx_ff - 1'b1;
               mem.wr_en   = 1'b1;
               mem.wr_addr = wr_idx[IDX_W-1:0];
               mem.wr_data = rd_data;
            end
            if (!iss_ff && !pend_ff) begin
               if (kind_ff == fpt_pkg::KIND_RAISE) begin
                  state_in = ST_PLACE;
               end else begin
                  count_in = count_ff - 1'b1;
                  idx_in   = '0;
                  eval_in  = eval_go;
                  state_in = eval_go ? ST_EVAL : ST_DONE;
               end
            end
         end

         ST_PLACE: begin
            mem.wr_en   = 1'b1;
            mem.wr_addr = fpos_ff[IDX_W-1:0];
            mem.wr_data = trig_ff;
            count_in    = count_ff + 1'b1;
            idx_in      = '0;
            pend_in     = 1'b0;
            eval_in     = eval_go;
            state_in    = eval_go ? ST_EVAL : ST_DONE;
         end

         ST_EVAL: begin
            pend_in = 1'b0;
            if (idx_ff < count_ff) begin
               pend_in = 1'b1;
               pidx_in = idx_ff;
               idx_in  = idx_next;
            end
            if (pend_ff) begin
               pm_in = pm_ff | cmp.move_pause;
               pl_in = pl_ff | cmp.pause_latched;
               em_in = em_ff | cmp.emergency;
            end
            if ((idx_ff >= count_ff) && !pend_ff) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (rsp_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The head of the table is mirrored so it never costs a read.
      if (mem.wr_en && (mem.wr_addr == '0)) begin
         top_code_in = mem.wr_data.code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
         iss_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         iss_ff   <= iss_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      handle_ff    <= handle_in;
      trig_ff      <= trig_in;
      idx_ff       <= idx_in;
      pidx_ff      <= pidx_in;
      found_ff     <= found_in;
      fpos_ff      <= fpos_in;
      ins_found_ff <= ins_found_in;
      ipos_ff      <= ipos_in;
      status_ff    <= status_in;
      eval_ff      <= eval_in;
      pm_ff        <= pm_in;
      pl_ff        <= pl_in;
      em_ff        <= em_in;
      top_code_ff  <= top_code_in;
   end

   assign idle = (state_ff == ST_IDLE);

   always_comb begin
      result.status        = status_ff;
      result.top_valid     = (count_ff != '0);
      result.top_code      = (count_ff != '0) ? top_code_ff : 16'd0;
      result.fault_count   = 6'(count_ff);
      result.evaluated     = eval_ff;
      result.move_pause    = pm_ff;
      result.pause_latched = pl_ff;
      result.emergency     = em_ff;
   end

endmodule

`default_nettype wire
